@@ rtl/led_pattern_sequencer_defines.svh @@
// Assertion macros shared by the LED pattern sequencer RTL.
// Included by modules that carry concurrent checks; depends on nothing else.
`ifndef LED_PATTERN_SEQUENCER_DEFINES_SVH
`define LED_PATTERN_SEQUENCER_DEFINES_SVH

// Check that is disabled while reset is high
`define LPS_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also holds during reset
`define LPS_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/lps_pkg.sv @@
// Shared types, constants and mode decode for the LED pattern sequencer.
// No dependencies; used by lps_csr and led_pattern_sequencer.
`default_nettype none

package lps_pkg;

   // LED port layout
   localparam int          NUM_ROWS_DEF = 6;
   localparam int          ROW_BITS     = 6;
   localparam logic [7:0]  PORT_OFF     = 8'hFF;
   localparam logic [7:0]  PORT_RED     = 8'hBF;
   localparam logic [7:0]  PORT_GREEN   = 8'h7F;
   localparam logic [7:0]  TOGGLE_RED   = 8'h40;
   localparam logic [7:0]  TOGGLE_GREEN = 8'h80;
   localparam logic [7:0]  TOGGLE_BOTH  = 8'hC0;

   // Configuration port
   localparam int          CSR_AW           = 3;
   localparam int          CSR_DW           = 32;
   localparam logic        REG_TOGGLE_TICKS = 1'b0;
   localparam logic [7:0]  TOGGLE_TICKS_RST = 8'd3;

   // Request kinds (tuser)
   localparam logic ACT_TICK   = 1'b0;
   localparam logic ACT_SELECT = 1'b1;

   // Mode request codes
   localparam logic [3:0] REQ_OFF          = 4'd0;
   localparam logic [3:0] REQ_RED          = 4'd1;
   localparam logic [3:0] REQ_RED_MOVING   = 4'd2;
   localparam logic [3:0] REQ_RED_BLINK    = 4'd3;
   localparam logic [3:0] REQ_GREEN        = 4'd4;
   localparam logic [3:0] REQ_GREEN_MOVING = 4'd5;
   localparam logic [3:0] REQ_GREEN_BLINK  = 4'd6;
   localparam logic [3:0] REQ_RG_MOVING    = 4'd7;
   localparam logic [3:0] REQ_RG_BLINK     = 4'd8;

   // Display mode, one-hot
   typedef enum logic [8:0] {
      MODE_OFF          = 9'b000000001,
      MODE_RED          = 9'b000000010,
      MODE_RED_MOVING   = 9'b000000100,
      MODE_RED_BLINK    = 9'b000001000,
      MODE_GREEN        = 9'b000010000,
      MODE_GREEN_MOVING = 9'b000100000,
      MODE_GREEN_BLINK  = 9'b001000000,
      MODE_RG_MOVING    = 9'b010000000,
      MODE_RG_BLINK     = 9'b100000000
   } mode_type;

   typedef struct packed {
      logic     valid;
      mode_type mode;
   } mode_dec_type;

   // Request code to mode; codes above the last mode are flagged invalid
   function automatic mode_dec_type decode_mode(input logic [3:0] code);
      mode_dec_type d;
      d.valid = 1'b1;
      d.mode  = MODE_OFF;
      case (code)
         REQ_OFF:          d.mode = MODE_OFF;
         REQ_RED:          d.mode = MODE_RED;
         REQ_RED_MOVING:   d.mode = MODE_RED_MOVING;
         REQ_RED_BLINK:    d.mode = MODE_RED_BLINK;
         REQ_GREEN:        d.mode = MODE_GREEN;
         REQ_GREEN_MOVING: d.mode = MODE_GREEN_MOVING;
         REQ_GREEN_BLINK:  d.mode = MODE_GREEN_BLINK;
         REQ_RG_MOVING:    d.mode = MODE_RG_MOVING;
         REQ_RG_BLINK:     d.mode = MODE_RG_BLINK;
         default:          d.valid = 1'b0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

@@ rtl/led_pattern_sequencer.sv @@
// LED pattern sequencer top level: input register, mode/pattern update, result word.
// Depends on lps_pkg, lps_csr and led_pattern_sequencer_defines.svh.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_tvalid/req_tready | tdata[3:0] mode_request, tuser action
//   rsp     | out       | rsp_tvalid/rsp_tready | tdata[7:0] port_value
//   csr     | in        | APB psel/penable      | toggle_ticks at byte address 0
//
// The result word is held in the port byte register behind the input register;
// one word per cycle is sustained while rsp is not stalled.
// The port byte register doubles as the result word, so a word is only updated
// when the previous one has been taken; a stall on rsp holds the input register,
// and req stays ready while that register is empty or moving on.
// Reset is synchronous: mode off, counters zero, port byte 0xFF, blink delay 3.
`default_nettype none

module led_pattern_sequencer #(
   parameter int NUM_ROWS = lps_pkg::NUM_ROWS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request stream
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [7:0]                 req_tdata,  // [3:0] mode_request, [7:4] zero
   input  wire logic                       req_tuser,  // [0] action
   // result stream
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic      [7:0]                 rsp_tdata,  // [7:0] port_value
   // configuration
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [lps_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [lps_pkg::CSR_DW-1:0] csr_pwdata,
   output logic      [lps_pkg::CSR_DW-1:0] csr_prdata,
   output logic                            csr_pready
);
   import lps_pkg::*;
`include "led_pattern_sequencer_defines.svh"

   localparam int              POS_W    = $clog2(2 * NUM_ROWS);
   localparam logic [POS_W:0]  ROWS_L   = (POS_W+1)'(NUM_ROWS);
   localparam logic [POS_W:0]  ROWS2_L  = (POS_W+1)'(2 * NUM_ROWS);
   localparam logic [POS_W-1:0] LAST_ROW = POS_W'(NUM_ROWS - 1);

   logic [7:0] toggle_ticks;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic       in_action_ff;
   logic [3:0] in_mode_ff;

   // display state; port_ff is also the result word
   mode_type         mode_ff, mode_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       wait_ff, wait_in;
   logic [7:0]       port_ff, port_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             take;
   logic             adv;
   mode_dec_type     dec;
   logic [POS_W:0]   pos_inc;
   logic [POS_W-1:0] pos_wrap;
   logic [8:0]       wait_inc;
   logic             blink_hit;

   // mode groups for the checks
   logic             blink_mode;
   logic             sweep_mode;
   logic             moving_mode;

   lps_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .toggle_ticks (toggle_ticks)
   );

   // red on, one row lit
   function automatic logic [7:0] red_row(input logic [POS_W-1:0] p);
      logic [ROW_BITS-1:0] rows;
      rows = ROW_BITS'(1) << p;
      return {1'b1, 1'b0, rows};
   endfunction

   // green on, rows counted from the top
   function automatic logic [7:0] green_row(input logic [POS_W-1:0] p);
      logic [POS_W-1:0]    r;
      logic [ROW_BITS-1:0] rows;
      r    = LAST_ROW - p;
      rows = ROW_BITS'(1) << r;
      return {1'b0, 1'b1, rows};
   endfunction

   // handshake
   assign adv         = in_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready  = ~in_valid_ff | adv;
   assign take        = req_tvalid & req_tready;
   assign in_valid_in = take | (in_valid_ff & ~adv);
   assign rsp_valid_in = adv | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (take) begin
         in_action_ff <= req_tuser;
         in_mode_ff   <= req_tdata[3:0];
      end
   end

   // counters shared by the tick paths
   assign dec       = decode_mode(in_mode_ff);
   assign pos_inc   = {1'b0, pos_ff} + (POS_W+1)'(1);
   assign wait_inc  = {1'b0, wait_ff} + 9'd1;
   assign blink_hit = wait_inc >= {1'b0, toggle_ticks};

   always_comb begin
      pos_wrap = pos_inc[POS_W-1:0];
      if (mode_ff == MODE_RG_MOVING) begin
         if (pos_inc >= ROWS2_L) pos_wrap = '0;
      end else begin
         if (pos_inc >= ROWS_L) pos_wrap = '0;
      end
   end

   // next state for one item
   always_comb begin
      mode_in = mode_ff;
      pos_in  = pos_ff;
      wait_in = wait_ff;
      port_in = port_ff;
      if (adv) begin
         if (in_action_ff == ACT_SELECT) begin
            if (dec.valid && dec.mode != mode_ff) begin
               mode_in = dec.mode;
               pos_in  = '0;
               wait_in = '0;
               case (dec.mode)
                  MODE_OFF:          port_in = PORT_OFF;
                  MODE_RED,
                  MODE_RED_BLINK,
                  MODE_RG_BLINK:     port_in = PORT_RED;
                  MODE_GREEN,
                  MODE_GREEN_BLINK:  port_in = PORT_GREEN;
                  MODE_RED_MOVING,
                  MODE_RG_MOVING:    port_in = red_row('0);
                  MODE_GREEN_MOVING: port_in = green_row('0);
                  default:           port_in = PORT_OFF;
               endcase
            end
         end else begin
            case (mode_ff)
               MODE_RED_MOVING: begin
                  pos_in  = pos_wrap;
                  port_in = red_row(pos_wrap);
               end
               MODE_GREEN_MOVING: begin
                  pos_in  = pos_wrap;
                  port_in = green_row(pos_wrap);
               end
               MODE_RG_MOVING: begin
                  pos_in = pos_wrap;
                  if ({1'b0, pos_wrap} >= ROWS_L) begin
                     port_in = green_row(pos_wrap - LAST_ROW - POS_W'(1));
                  end else begin
                     port_in = red_row(pos_wrap);
                  end
               end
               MODE_RED_BLINK,
               MODE_GREEN_BLINK,
               MODE_RG_BLINK: begin
                  if (blink_hit) begin
                     wait_in = '0;
                     if (mode_ff == MODE_RED_BLINK) begin
                        port_in = port_ff ^ TOGGLE_RED;
                     end else if (mode_ff == MODE_GREEN_BLINK) begin
                        port_in = port_ff ^ TOGGLE_GREEN;
                     end else begin
                        port_in = port_ff ^ TOGGLE_BOTH;
                     end
                  end else begin
                     wait_in = wait_inc[7:0];
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_OFF;
         pos_ff       <= '0;
         wait_ff      <= '0;
         port_ff      <= PORT_OFF;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         pos_ff       <= pos_in;
         wait_ff      <= wait_in;
         port_ff      <= port_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = port_ff;

   // checks
   assign blink_mode  = (mode_ff == MODE_RED_BLINK) | (mode_ff == MODE_GREEN_BLINK) |
                        (mode_ff == MODE_RG_BLINK);
   assign sweep_mode  = (mode_ff == MODE_RED_MOVING) | (mode_ff == MODE_GREEN_MOVING);
   assign moving_mode = sweep_mode | (mode_ff == MODE_RG_MOVING);

   `LPS_ASSERT(a_off_dark, clock, reset,
      (mode_ff == MODE_OFF) |-> (port_ff == PORT_OFF), "off mode with LEDs driven")
   `LPS_ASSERT(a_wait_idle, clock, reset,
      !blink_mode |-> (wait_ff == 8'd0), "tick count outside blink mode")
   `LPS_ASSERT(a_one_row, clock, reset,
      moving_mode |-> $onehot(port_ff[ROW_BITS-1:0]), "moving mode without exactly one row lit")
   `LPS_ASSERT(a_pos_range, clock, reset,
      sweep_mode |-> ({1'b0, pos_ff} < ROWS_L), "row position out of range")
   `LPS_ASSERT(a_hold_stall, clock, reset,
      (rsp_valid_ff && !rsp_tready) |=> (port_ff == $past(port_ff) && mode_ff == $past(mode_ff)),
      "state moved while result stalled")

endmodule

`default_nettype wire

@@ rtl/lps_csr.sv @@
// APB-style register block holding the blink delay.
// Depends on lps_pkg for address width, register index and reset value.
`default_nettype none

module lps_csr (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [lps_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [lps_pkg::CSR_DW-1:0] csr_pwdata,
   output logic      [lps_pkg::CSR_DW-1:0] csr_prdata,
   output logic                            csr_pready,
   output logic      [7:0]                 toggle_ticks
);
   import lps_pkg::*;

   logic [7:0] toggle_ticks_ff;
   logic [7:0] toggle_ticks_in;
   logic       reg_index;
   logic       wr_en;

   // word index: one register per 4 bytes
   assign reg_index  = csr_paddr[CSR_AW-1];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;

   // write decode
   always_comb begin
      toggle_ticks_in = toggle_ticks_ff;
      if (wr_en && reg_index == REG_TOGGLE_TICKS) begin
         toggle_ticks_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         toggle_ticks_ff <= TOGGLE_TICKS_RST;
      end else begin
         toggle_ticks_ff <= toggle_ticks_in;
      end
   end

   // read mux
   always_comb begin
      csr_prdata = '0;
      if (reg_index == REG_TOGGLE_TICKS) begin
         csr_prdata = {{(CSR_DW-8){1'b0}}, toggle_ticks_ff};
      end
   end

   assign toggle_ticks = toggle_ticks_ff;

endmodule

`default_nettype wire

@@ tb/sv/tb_led_pattern_sequencer.sv @@
// Self-checking testbench for led_pattern_sequencer: mode selects and ticks go in on req,
// every port byte on rsp is checked against a cycle-free model of the LED sequencer.
// Depends on lps_pkg and the led_pattern_sequencer RTL only.
module tb_led_pattern_sequencer;
   timeunit 1ns;
   timeprecision 1ps;

   import lps_pkg::*;

   localparam int          ROWS        = NUM_ROWS_DEF;
   localparam logic [7:0]  ROW_MASK    = 8'h3F;
   localparam int          CYCLE_LIMIT = 500000;
   localparam logic [CSR_AW-1:0] TOGGLE_TICKS_ADDR = {REG_TOGGLE_TICKS, 2'b00};

   typedef struct packed {
      logic       action;
      logic [3:0] code;
   } led_request_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #1 clock = ~clock;

   // DUT inputs, all at known values from time zero
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata   = 8'h00;  // [3:0] mode_request, [7:4] zero
   logic              req_tuser   = 1'b0;   // [0] action
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [7:0]        rsp_tdata;            // [7:0] port_value
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr   = '0;
   logic [CSR_DW-1:0] csr_pwdata  = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   led_pattern_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // stimulus and expected port bytes
   led_request_type pending_requests[$];
   logic [7:0]      expected_ports[$];

   int errors       = 0;
   int selects_seen = 0;
   int ticks_seen   = 0;
   int words_seen   = 0;
   int delay_writes = 0;

   // display model state
   logic [3:0] disp_mode;
   logic [3:0] disp_pos;
   logic [7:0] disp_wait;
   logic [7:0] disp_port;
   logic [7:0] toggle_ticks_q;

   function automatic logic [7:0] red_row_value(input int row);
      return TOGGLE_GREEN | (ROW_MASK & (8'h01 << row));
   endfunction

   function automatic logic [7:0] green_row_value(input int row);
      return TOGGLE_RED | (ROW_MASK & (8'h01 << (ROWS - 1 - row)));
   endfunction

   // Applies one request word to the model, returns the port byte after it
   function automatic logic [7:0] next_port_value(input logic act, input logic [3:0] code);
      int         pos_next;
      logic [8:0] wait_next;
      logic [7:0] flip;
      flip = 8'h00;
      if (act == ACT_SELECT) begin
         // codes past the last mode and a repeat of the current mode change nothing
         if (code <= REQ_RG_BLINK && code != disp_mode) begin
            disp_mode = code;
            disp_pos  = 4'd0;
            disp_wait = 8'd0;
            case (code)
               REQ_OFF:                              disp_port = PORT_OFF;
               REQ_RED, REQ_RED_BLINK, REQ_RG_BLINK: disp_port = PORT_RED;
               REQ_GREEN, REQ_GREEN_BLINK:           disp_port = PORT_GREEN;
               REQ_RED_MOVING, REQ_RG_MOVING:        disp_port = red_row_value(0);
               default:                              disp_port = green_row_value(0);
            endcase
         end
      end else begin
         pos_next = int'(disp_pos) + 1;
         case (disp_mode)
            REQ_RED_MOVING, REQ_GREEN_MOVING: begin
               if (pos_next >= ROWS) pos_next = 0;
               disp_pos  = pos_next[3:0];
               disp_port = (disp_mode == REQ_RED_MOVING) ? red_row_value(pos_next)
                                                         : green_row_value(pos_next);
            end
            // red sweep for the first half of the count, green sweep for the second
            REQ_RG_MOVING: begin
               if (pos_next >= 2 * ROWS) pos_next = 0;
               disp_pos  = pos_next[3:0];
               disp_port = (pos_next >= ROWS) ? green_row_value(pos_next - ROWS)
                                              : red_row_value(pos_next);
            end
            REQ_RED_BLINK:   flip = TOGGLE_RED;
            REQ_GREEN_BLINK: flip = TOGGLE_GREEN;
            REQ_RG_BLINK:    flip = TOGGLE_BOTH;
            default: ;
         endcase
         // blink count: a delay of zero, or one below the count, toggles at once
         if (flip != 8'h00) begin
            wait_next = {1'b0, disp_wait} + 9'd1;
            if (wait_next >= {1'b0, toggle_ticks_q}) begin
               disp_port = disp_port ^ flip;
               disp_wait = 8'd0;
            end else begin
               disp_wait = wait_next[7:0];
            end
         end
      end
      return disp_port;
   endfunction

   // idle lengths: mostly short, a few long
   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // request driver
   led_request_type req_next;
   int              req_gap     = 0;
   logic            req_idle_on = 1'b1;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_ports.push_back(next_port_value(req_tuser, req_tdata[3:0]));
            if (req_tuser == ACT_SELECT) selects_seen++;
            else ticks_seen++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() == 0) begin
               req_tvalid <= 1'b0;
            end else begin
               req_next = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {4'b0000, req_next.code};
               req_tuser  <= req_next.action;
               if ($urandom_range(0, 63) == 0) req_idle_on = !req_idle_on;
               req_gap = req_idle_on ? pick_idle() : 0;
            end
         end
      end
   end

   // result monitor and back-pressure
   int   rsp_stall   = 0;
   logic rsp_idle_on = 1'b1;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            words_seen++;
            if (expected_ports.size() == 0) begin
               $error("unexpected word: port_value actual %02h", rsp_tdata);
               errors++;
            end else if (rsp_tdata !== expected_ports[0]) begin
               $error("port_value mismatch: expected %02h, actual %02h",
                      expected_ports[0], rsp_tdata);
               errors++;
               void'(expected_ports.pop_front());
            end else begin
               void'(expected_ports.pop_front());
            end
            if ($urandom_range(0, 63) == 0) rsp_idle_on = !rsp_idle_on;
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_idle_on && $urandom_range(0, 3) == 0) rsp_stall = pick_idle();
         end
      end
   end

   // watchdog
   int cycles = 0;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding",
                  cycles, expected_ports.size());
         $display("status: fail");
         $finish;
      end
   end

   task automatic push_request(input logic act, input logic [3:0] code);
      led_request_type item;
      item.action = act;
      item.code   = code;
      pending_requests.push_back(item);
   endtask

   // ticks carry random code bits, which the block must ignore
   task automatic push_ticks(input int count);
      for (int i = 0; i < count; i++) push_request(ACT_TICK, 4'($urandom_range(0, 15)));
   endtask

   // wait until every queued word is sent and every result has come back
   task automatic drain();
      while (pending_requests.size() != 0 || req_tvalid || expected_ports.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // APB write of the blink delay; only called while the block is idle
   task automatic write_toggle_ticks(input logic [7:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= TOGGLE_TICKS_ADDR;
      csr_pwdata  <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      toggle_ticks_q = value;
      delay_writes++;
   endtask

   // mostly a mode select followed by a run of ticks; some unknown codes and noise
   task automatic push_random(input int count);
      int queued;
      int r;
      int run;
      logic [3:0] mode;
      queued = 0;
      while (queued < count) begin
         r = $urandom_range(0, 99);
         if (r < 80) begin
            mode = 4'($urandom_range(0, 8));
            run  = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 16);
            push_request(ACT_SELECT, mode);
            push_ticks(run);
            queued += run + 1;
            // reselect the running mode now and then, it must not restart
            if ($urandom_range(0, 4) == 0) begin
               push_request(ACT_SELECT, mode);
               push_ticks(3);
               queued += 4;
            end
         end else if (r < 90) begin
            push_request(ACT_SELECT, 4'($urandom_range(9, 15)));
            queued++;
         end else begin
            push_request(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
            queued++;
         end
      end
   endtask

   initial begin
      int phase_delay;

      disp_mode      = REQ_OFF;
      disp_pos       = 4'd0;
      disp_wait      = 8'd0;
      disp_port      = PORT_OFF;
      toggle_ticks_q = TOGGLE_TICKS_RST;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed walk through every mode at the reset blink delay
      push_ticks(1);
      push_request(ACT_SELECT, REQ_OFF);
      push_request(ACT_SELECT, REQ_RED);
      push_request(ACT_SELECT, REQ_RED);
      push_request(ACT_SELECT, REQ_RED_MOVING);
      push_ticks(6);
      push_request(ACT_SELECT, REQ_RED_BLINK);
      push_ticks(3);
      push_request(ACT_SELECT, REQ_GREEN);
      push_request(ACT_SELECT, REQ_GREEN_MOVING);
      push_ticks(2);
      push_request(ACT_SELECT, REQ_GREEN_BLINK);
      push_ticks(3);
      push_request(ACT_SELECT, REQ_RG_MOVING);
      push_ticks(12);
      push_request(ACT_SELECT, REQ_RG_BLINK);
      push_ticks(3);
      push_request(ACT_SELECT, 4'd9);
      push_request(ACT_SELECT, 4'd15);
      push_ticks(1);
      drain();

      // shortest delay
      write_toggle_ticks(8'd1);
      push_random(150);
      drain();

      // longest delay: runs past the first toggle
      write_toggle_ticks(8'd255);
      push_request(ACT_SELECT, REQ_OFF);
      push_request(ACT_SELECT, REQ_RG_BLINK);
      push_ticks(260);
      push_random(50);
      drain();

      // delay lowered below the running count toggles on the next tick
      write_toggle_ticks(8'd200);
      push_request(ACT_SELECT, REQ_OFF);
      push_request(ACT_SELECT, REQ_GREEN_BLINK);
      push_ticks(10);
      drain();
      write_toggle_ticks(8'd4);
      push_ticks(3);
      push_random(100);
      drain();

      // zero delay acts as one
      write_toggle_ticks(8'd0);
      push_request(ACT_SELECT, REQ_OFF);
      push_request(ACT_SELECT, REQ_RED_BLINK);
      push_ticks(4);
      push_random(100);
      drain();

      for (int p = 0; p < 3; p++) begin
         phase_delay = $urandom_range(1, 12);
         write_toggle_ticks(8'(phase_delay));
         push_random(120);
         drain();
      end

      repeat (10) @(posedge clock);
      if (expected_ports.size() != 0) begin
         $error("%0d port bytes never arrived", expected_ports.size());
         errors++;
      end
      $display("covered %0d mode selects and %0d ticks over %0d blink delay settings,",
               selects_seen, ticks_seen, delay_writes + 1);
      $display("checked %0d port bytes with %0d mismatches", words_seen, errors);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
